FILE: hw/rtl/crystal_misorientation_min_top_assert.svh
// Assertion macros for the crystal misorientation search block
`ifndef CRYSTAL_MISORIENTATION_MIN_TOP_ASSERT_SVH
`define CRYSTAL_MISORIENTATION_MIN_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle
`define CMM_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle
`define CMM_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/cmm_pkg.sv
// Types, constants and symmetry operator tables for the misorientation search
`default_nettype none
package cmm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IDX_W     = 10;
    localparam int CLASS_MAX = 10;

    typedef logic signed [15:0] comp_t;
    typedef comp_t [3:0] quat_t;          // [0]=w [1]=x [2]=y [3]=z
    typedef logic signed [16:0] compw_t;
    typedef compw_t [3:0] quatw_t;

    // Kind of work carried by a multiplier beat
    localparam logic [1:0] K_BUILD = 2'd0;
    localparam logic [1:0] K_DIFF  = 2'd1;
    localparam logic [1:0] K_TRIAL = 2'd2;

    typedef struct packed {
        logic             vld;
        logic [1:0]       kind;
        logic [IDX_W-1:0] idx;
        logic             last;
    } tag_t;

    localparam comp_t ONE_Q = comp_t'(1 << FRAC_BITS);
    localparam comp_t R2_Q  = 16'sd11585;
    localparam comp_t R3_Q  = 16'sd14189;
    localparam comp_t H_Q   = comp_t'(1 << (FRAC_BITS - 1));

    // Operator code to value: odd codes 1-7 positive, even codes 2-8 negative, others zero
    function automatic comp_t op_val(input logic [3:0] code);
        comp_t v;
        v = '0;
        case (code)
            4'd1: v = ONE_Q;
            4'd2: v = -ONE_Q;
            4'd3: v = R2_Q;
            4'd4: v = -R2_Q;
            4'd5: v = R3_Q;
            4'd6: v = -R3_Q;
            4'd7: v = H_Q;
            4'd8: v = -H_Q;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Base rotation operators, one hex nibble per component w x y z
    function automatic logic [15:0] base_code(input logic [5:0] sel);
        logic [15:0] c;
        c = 16'h1000;
        case (sel)
            6'd0:  c = 16'h1000; 6'd1:  c = 16'h0010; 6'd2:  c = 16'h0100;
            6'd3:  c = 16'h0001; 6'd4:  c = 16'h3004; 6'd5:  c = 16'h3003;
            6'd6:  c = 16'h0330; 6'd7:  c = 16'h0430;
            6'd8:  c = 16'h1000; 6'd9:  c = 16'h8005; 6'd10: c = 16'h7005;
            6'd11: c = 16'h5008; 6'd12: c = 16'h0001; 6'd13: c = 16'h5007;
            6'd14: c = 16'h0850; 6'd15: c = 16'h0100; 6'd16: c = 16'h0750;
            6'd17: c = 16'h0570; 6'd18: c = 16'h0010; 6'd19: c = 16'h0580;
            6'd20: c = 16'h1000; 6'd21: c = 16'h7777; 6'd22: c = 16'h8777;
            6'd23: c = 16'h7877; 6'd24: c = 16'h7787; 6'd25: c = 16'h8887;
            6'd26: c = 16'h7887; 6'd27: c = 16'h8877; 6'd28: c = 16'h8787;
            6'd29: c = 16'h0010; 6'd30: c = 16'h0001; 6'd31: c = 16'h0100;
            6'd32: c = 16'h0807; 6'd33: c = 16'h0707; 6'd34: c = 16'h7070;
            6'd35: c = 16'h7080; 6'd36: c = 16'h0087; 6'd37: c = 16'h7700;
            6'd38: c = 16'h7800; 6'd39: c = 16'h0077; 6'd40: c = 16'h0870;
            6'd41: c = 16'h7008; 6'd42: c = 16'h0770; 6'd43: c = 16'h7007;
            default: c = 16'h1000;
        endcase
        return c;
    endfunction

    // Number of operators in each point group
    function automatic logic [4:0] class_len(input logic [3:0] cls);
        logic [4:0] n;
        n = 5'd1;
        case (cls)
            4'd0:  n = 5'd24;
            4'd1:  n = 5'd12;
            4'd2:  n = 5'd12;
            4'd3:  n = 5'd6;
            4'd4:  n = 5'd6;
            4'd5:  n = 5'd3;
            4'd6:  n = 5'd8;
            4'd7:  n = 5'd4;
            4'd8:  n = 5'd4;
            4'd9:  n = 5'd2;
            default: n = 5'd1;
        endcase
        return n;
    endfunction

    // Operator i of a point group as a quaternion
    function automatic quat_t op_quat(input logic [3:0] cls, input logic [4:0] i);
        logic [5:0]  sel;
        logic [15:0] c;
        quat_t       q;
        sel = {1'b0, i};
        case (cls)
            4'd0, 4'd1:       sel = 6'd20 + {1'b0, i};
            4'd2, 4'd4, 4'd5: sel = 6'd8 + {1'b0, i};
            4'd3:             sel = (i < 5'd3) ? 6'd8 + {1'b0, i} : 6'd14 + {1'b0, i};
            4'd7:             sel = (i == 5'd0) ? 6'd0 : 6'd2 + {1'b0, i};
            default:          sel = {1'b0, i};
        endcase
        c = base_code(sel);
        q[0] = op_val(c[15:12]);
        q[1] = op_val(c[11:8]);
        q[2] = op_val(c[7:4]);
        q[3] = op_val(c[3:0]);
        return q;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/crystal_misorientation_min_top.sv
// Top level of the crystal misorientation search
`default_nettype none
// Finds, for two orientation quaternions a and b (Q2.14), the symmetry
// equivalent of a*conj(b) with the largest scalar part, i.e. the smallest
// rotation angle, and its index in the symmetry product table. The table
// (all products op_i*op_j of the selected point group) lives in one RAM and
// is rebuilt after reset and after each valid crystal_class write, one entry
// per cycle, during which in_stall stays high. An item is accepted, then the
// difference quaternion is formed, and each table entry is read and sent
// through the shared two-stage quaternion multiplier, followed by the
// pipeline tail and hand-off. The RAM read port sets the rate: one table
// entry per cycle. A finished result waits in the output register while
// the next item is taken; a search that finishes while that register is
// still full waits until it is read.
module crystal_misorientation_min_top #(
    parameter int MAX_OPS    = 24,
    parameter int MAX_MISOPS = 576
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [3:0]          cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire cmm_pkg::comp_t      a_w,
    input  wire cmm_pkg::comp_t      a_x,
    input  wire cmm_pkg::comp_t      a_y,
    input  wire cmm_pkg::comp_t      a_z,
    input  wire cmm_pkg::comp_t      b_w,
    input  wire cmm_pkg::comp_t      b_x,
    input  wire cmm_pkg::comp_t      b_y,
    input  wire cmm_pkg::comp_t      b_z,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output cmm_pkg::comp_t           mis_w,
    output cmm_pkg::comp_t           mis_x,
    output cmm_pkg::comp_t           mis_y,
    output cmm_pkg::comp_t           mis_z,
    output logic [cmm_pkg::IDX_W-1:0] best_index
);
    import cmm_pkg::*;

    localparam int AW  = (MAX_MISOPS > 1) ? $clog2(MAX_MISOPS) : 1;
    localparam int CW  = $clog2(MAX_MISOPS + 1);
    localparam int OPW = $clog2(MAX_OPS + 1);

    localparam logic [2:0] ST_BUILD  = 3'd0;
    localparam logic [2:0] ST_DRAIN  = 3'd1;
    localparam logic [2:0] ST_IDLE   = 3'd2;
    localparam logic [2:0] ST_DIFF   = 3'd3;
    localparam logic [2:0] ST_SEARCH = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]     state_reg, state_next;
    logic [3:0]     class_reg, class_next;
    logic [OPW-1:0] i_reg, i_next, j_reg, j_next, n_ops;
    logic [CW-1:0]  cnt_reg, cnt_next, count_reg, count_next;
    logic [AW-1:0]  s_addr_reg, s_addr_next;
    logic           rd_vld_reg, rd_vld_next, rd_last_reg, rd_last_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    quat_t          d_reg;
    logic           out_vld_reg, out_vld_next;
    quat_t          mis_reg;
    logic [IDX_W-1:0] idx_out_reg;

    tag_t           q_in_tag, q_out_tag;
    quat_t          q_p, q_r, best;
    quatw_t         q_q;
    quat_t          op_j;
    logic           q_busy;
    logic [IDX_W-1:0] best_idx;
    logic [63:0]    rdata;
    logic           in_acc, cfg_ok, build_last;
    logic [4:0]     len;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign cfg_ok   = cfg_we && (cfg_wdata <= 4'(CLASS_MAX));
    assign len      = class_len(class_reg);
    assign n_ops    = (32'(len) > MAX_OPS) ? OPW'(MAX_OPS) : OPW'(len);
    assign op_j     = op_quat(class_reg, 5'(j_reg));
    assign build_last = (32'(cnt_reg) + 1 == MAX_MISOPS)
        || ((i_reg == n_ops - 1'b1) && (j_reg == n_ops - 1'b1));

    // multiplier operand selection
    always_comb
    begin
        q_in_tag = '0;
        q_p      = '0;
        q_q      = '0;
        if (rd_vld_reg)
        begin
            q_in_tag.vld  = 1'b1;
            q_in_tag.kind = K_TRIAL;
            q_in_tag.idx  = rd_idx_reg;
            q_in_tag.last = rd_last_reg;
            q_p = quat_t'(rdata);
            for (int k = 0; k < 4; k++)
            begin
                q_q[k] = 17'(d_reg[k]);
            end
        end
        else if (state_reg == ST_BUILD)
        begin
            q_in_tag.vld  = 1'b1;
            q_in_tag.kind = K_BUILD;
            q_in_tag.idx  = IDX_W'(cnt_reg);
            q_p = op_quat(class_reg, 5'(i_reg));
            for (int k = 0; k < 4; k++)
            begin
                q_q[k] = 17'(op_j[k]);
            end
        end
        else
        begin
            q_in_tag.vld  = in_acc;
            q_in_tag.kind = K_DIFF;
            q_p[0] = a_w;
            q_p[1] = a_x;
            q_p[2] = a_y;
            q_p[3] = a_z;
            q_q[0] = 17'(b_w);
            q_q[1] = -17'(b_x);
            q_q[2] = -17'(b_y);
            q_q[3] = -17'(b_z);
        end
    end

    cmm_qmul u_qmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (q_in_tag),
        .p       (q_p),
        .q       (q_q),
        .out_tag (q_out_tag),
        .r       (q_r),
        .busy    (q_busy)
    );

    cmm_ram #(
        .WIDTH (64),
        .DEPTH (MAX_MISOPS)
    ) u_table (
        .clk   (clk),
        .we    (q_out_tag.vld && (q_out_tag.kind == K_BUILD)),
        .waddr (AW'(q_out_tag.idx)),
        .wdata (64'(q_r)),
        .raddr (s_addr_reg),
        .rdata (rdata)
    );

    cmm_best u_best (
        .clk      (clk),
        .tag      (q_out_tag),
        .r        (q_r),
        .best     (best),
        .best_idx (best_idx)
    );

    // sequencer: table build, difference, search, result hand-off
    always_comb
    begin
        state_next   = state_reg;
        class_next   = class_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        cnt_next     = cnt_reg;
        count_next   = count_reg;
        s_addr_next  = s_addr_reg;
        rd_vld_next  = 1'b0;
        rd_last_next = 1'b0;
        rd_idx_next  = rd_idx_reg;
        out_vld_next = out_vld_reg && out_stall;
        case (state_reg)
            ST_BUILD:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (build_last)
                begin
                    count_next = cnt_reg + 1'b1;
                    state_next = ST_DRAIN;
                end
                else if (j_reg == n_ops - 1'b1)
                begin
                    j_next = '0;
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!q_busy)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                s_addr_next = '0;
                if (q_out_tag.vld && (q_out_tag.kind == K_DIFF))
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                rd_vld_next  = 1'b1;
                rd_idx_next  = IDX_W'(s_addr_reg);
                rd_last_next = (CW'(s_addr_reg) == count_reg - 1'b1);
                if (rd_last_next)
                    state_next = ST_FINISH;
                else
                    s_addr_next = s_addr_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (q_out_tag.vld && (q_out_tag.kind == K_TRIAL) && q_out_tag.last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_vld_reg || !out_stall)
                begin
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // a valid class write restarts the table build
        if (cfg_ok)
        begin
            class_next = cfg_wdata;
            state_next = ST_BUILD;
            i_next     = '0;
            j_next     = '0;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_BUILD;
            class_reg   <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            cnt_reg     <= '0;
            count_reg   <= '0;
            s_addr_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            rd_idx_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            class_reg   <= class_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            cnt_reg     <= cnt_next;
            count_reg   <= count_next;
            s_addr_reg  <= s_addr_next;
            rd_vld_reg  <= rd_vld_next;
            rd_last_reg <= rd_last_next;
            rd_idx_reg  <= rd_idx_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload: difference quaternion and output beat
    always_ff @(posedge clk)
    begin
        if (q_out_tag.vld && (q_out_tag.kind == K_DIFF))
            d_reg <= q_r;
        if ((state_reg == ST_DONE) && (!out_vld_reg || !out_stall))
        begin
            mis_reg     <= best;
            idx_out_reg <= best_idx;
        end
    end

    assign out_valid  = out_vld_reg;
    assign mis_w      = mis_reg[0];
    assign mis_x      = mis_reg[1];
    assign mis_y      = mis_reg[2];
    assign mis_z      = mis_reg[3];
    assign best_index = idx_out_reg;

`include "crystal_misorientation_min_top_assert.svh"

    `CMM_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted beat did not stall input")
    `CMM_IMPLIES(a_out_from_done, $rose(out_valid), $past(state_reg) == ST_DONE, "result without finished search")
    `CMM_IMPLIES(a_trial_in_range, q_out_tag.vld && (q_out_tag.kind == K_TRIAL), 32'(q_out_tag.idx) < 32'(count_reg), "trial index beyond table")

endmodule
`default_nettype wire

FILE: hw/rtl/cmm_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module cmm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 576
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/cmm_qmul.sv
// Two-stage quaternion multiplier: products, then sum, round and saturate
`default_nettype none
module cmm_qmul (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cmm_pkg::tag_t  in_tag,
    input  wire cmm_pkg::quat_t p,
    input  wire cmm_pkg::quatw_t q,
    output cmm_pkg::tag_t       out_tag,
    output cmm_pkg::quat_t      r,
    output logic                busy
);
    import cmm_pkg::*;

    logic signed [32:0] prod_reg [4][4];
    tag_t               s1_tag_reg;
    tag_t               out_tag_reg;
    quat_t              r_reg;
    logic signed [34:0] sum [4];
    quat_t              r_next;

    function automatic comp_t rnd_sat(input logic signed [34:0] v);
        logic signed [34:0] s;
        s = (v + 35'sd8192) >>> FRAC_BITS;
        if (s > 35'sd32767)
            return 16'sd32767;
        else if (s < -35'sd32768)
            return -16'sd32768;
        else
            return s[15:0];
    endfunction

    // stage 1: all sixteen component products
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 4; a++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                prod_reg[a][b] <= $signed(p[a]) * $signed(q[b]);
            end
        end
    end

    // stage 2: Hamilton sums
    always_comb
    begin
        sum[0] = 35'(prod_reg[0][0]) - 35'(prod_reg[1][1])
               - 35'(prod_reg[2][2]) - 35'(prod_reg[3][3]);
        sum[1] = 35'(prod_reg[0][1]) + 35'(prod_reg[1][0])
               + 35'(prod_reg[2][3]) - 35'(prod_reg[3][2]);
        sum[2] = 35'(prod_reg[0][2]) - 35'(prod_reg[1][3])
               + 35'(prod_reg[2][0]) + 35'(prod_reg[3][1]);
        sum[3] = 35'(prod_reg[0][3]) + 35'(prod_reg[1][2])
               - 35'(prod_reg[2][1]) + 35'(prod_reg[3][0]);
        for (int k = 0; k < 4; k++)
        begin
            r_next[k] = rnd_sat(sum[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
    end

    // tags travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg  <= '0;
            out_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg  <= in_tag;
            out_tag_reg <= s1_tag_reg;
        end
    end

    assign out_tag = out_tag_reg;
    assign r       = r_reg;
    assign busy    = s1_tag_reg.vld | out_tag_reg.vld;
endmodule
`default_nettype wire

FILE: hw/rtl/cmm_best.sv
// Running best trial: largest clamped scalar part, first one on ties
`default_nettype none
module cmm_best (
    input  wire logic           clk,
    input  wire cmm_pkg::tag_t  tag,
    input  wire cmm_pkg::quat_t r,
    output cmm_pkg::quat_t      best,
    output logic [cmm_pkg::IDX_W-1:0] best_idx
);
    import cmm_pkg::*;

    comp_t            w_clamp;
    comp_t            bestw_reg;
    quat_t            best_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             take;

    always_comb
    begin
        if (r[0] > ONE_Q)
            w_clamp = ONE_Q;
        else if (r[0] < -ONE_Q)
            w_clamp = -ONE_Q;
        else
            w_clamp = r[0];
        take = tag.vld && (tag.kind == K_TRIAL)
            && ((tag.idx == '0) || (w_clamp > bestw_reg));
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            bestw_reg <= w_clamp;
            best_reg  <= r;
            idx_reg   <= tag.idx;
        end
    end

    assign best     = best_reg;
    assign best_idx = idx_reg;
endmodule
`default_nettype wire
